// ===== rtl/drid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drid_pkg: shared types and constants for the resistor-ID detector
// Command codes, device kinds, register indexes and the input and output words.
// ----------------------------------------------------------------------------
package drid_pkg;

	localparam bit HAS_DOCK = 1'b1;

	localparam int CNT_W = 10;
	localparam int MV_W  = 12;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_EDGE     = 3'd1,
		CMD_SAMPLE   = 3'd2,
		CMD_FORCE    = 3'd3,
		CMD_INIT     = 3'd4,
		CMD_SHUTDOWN = 3'd5
	} cmd_t;

	localparam logic [2:0] KIND_ERROR    = 3'd0;
	localparam logic [2:0] KIND_UNKNOWN  = 3'd1;
	localparam logic [2:0] KIND_DETACHED = 3'd2;
	localparam logic [2:0] KIND_DOCK     = 3'd3;
	localparam logic [2:0] KIND_KEYBOARD = 3'd4;

	localparam logic [1:0] FORCE_DETACH = 2'd0;
	localparam logic [1:0] FORCE_ATTACH = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DET_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DET_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DOCK_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DOCK_HIGH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_KB_LOW    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_KB_HIGH   = 3'd7;

	typedef struct packed {
		logic [2:0]      cmd;
		logic [MV_W-1:0] sample_mv;
		logic            sample_error;
		logic [1:0]      force_value;
		logic            vbus_present;
	} in_word_t;

	typedef struct packed {
		logic       sample_request;
		logic       power_enable;
		logic       charge_enable;
		logic       base_attached;
		logic [2:0] device_kind;
		logic       external_power;
		logic       pin_watch_enabled;
	} out_word_t;

	// voltage windows, inclusive bounds
	typedef struct packed {
		logic [MV_W-1:0] det_low;
		logic [MV_W-1:0] det_high;
		logic [MV_W-1:0] dock_low;
		logic [MV_W-1:0] dock_high;
		logic [MV_W-1:0] kb_low;
		logic [MV_W-1:0] kb_high;
	} windows_t;

endpackage

// ===== rtl/debounced_resistor_id_detect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_resistor_id_detect: debounced accessory detect by divider voltage
// Event-driven detector: ticks, pin edges, converter samples and commands in,
// one status word out per event.
// ----------------------------------------------------------------------------
//  channel  | signals                          | word
//  ---------+----------------------------------+----------------------------
//  in       | in_valid / in_ready / in_word    | in_word_t, one event
//  out      | out_valid / out_ready / out_word | out_word_t, status after it
//  cfg      | cfg_we / cfg_index / cfg_data    | 12-bit register write
//
//  Path: input accept into the input register, then the state update
//  into the output register. Throughput: one word per cycle while the
//  output is taken, set by the state update loop.
//  Reset: arst_n clears all control state and loads the register defaults.
//  Stalls: a held output word stops the state update; the input register
//  keeps its word and in_ready drops until the output is taken.
// ----------------------------------------------------------------------------
module debounced_resistor_id_detect
	import drid_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MV_W-1:0]      cfg_data
);

	// detector state
	typedef struct packed {
		logic [CNT_W-1:0] countdown;
		logic             timer_armed;
		logic             awaiting;
		logic             watch;
		logic [2:0]       kind;
		logic             power_on;
		logic             charge_on;
		logic             attached;
	} det_state_t;

	// configuration registers
	logic [CNT_W-1:0] debounce_q;
	logic [CNT_W-1:0] retry_q;
	windows_t         win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q      <= 10'd20;
			retry_q         <= 10'd500;
			win_q.det_low   <= 12'd2700;
			win_q.det_high  <= 12'd3500;
			win_q.dock_low  <= 12'd141;
			win_q.dock_high <= 12'd173;
			win_q.kb_low    <= 12'd270;
			win_q.kb_high   <= 12'd400;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:  debounce_q      <= cfg_data[CNT_W-1:0];
				CFG_RETRY:     retry_q         <= cfg_data[CNT_W-1:0];
				CFG_DET_LOW:   win_q.det_low   <= cfg_data;
				CFG_DET_HIGH:  win_q.det_high  <= cfg_data;
				CFG_DOCK_LOW:  win_q.dock_low  <= cfg_data;
				CFG_DOCK_HIGH: win_q.dock_high <= cfg_data;
				CFG_KB_LOW:    win_q.kb_low    <= cfg_data;
				CFG_KB_HIGH:   win_q.kb_high   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: input register
	in_word_t word_s1;
	logic     valid_s1;
	logic     advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

	// classify the sampled voltage
	logic [2:0] sample_kind;

	drid_classify u_classify (
		.mv   (word_s1.sample_mv),
		.err  (word_s1.sample_error),
		.win  (win_q),
		.kind (sample_kind)
	);

	// state update
	det_state_t st_q, st_d, st_kind;
	logic [2:0]       kind_to_apply;
	logic [CNT_W-1:0] cnt_dec;

	// force attach/detach picks keyboard or detached, a sample its reading
	assign kind_to_apply = (word_s1.cmd == CMD_FORCE) ?
	                       ((word_s1.force_value == FORCE_ATTACH) ?
	                        KIND_KEYBOARD : KIND_DETACHED) :
	                       sample_kind;

	// outputs follow the recognized kind; error/unknown rearm the retry timer
	always_comb begin
		st_kind      = st_q;
		st_kind.kind = kind_to_apply;
		case (kind_to_apply)
			KIND_DETACHED: begin
				st_kind.power_on  = 1'b0;
				st_kind.charge_on = 1'b0;
				st_kind.attached  = 1'b0;
			end
			KIND_DOCK: begin
				st_kind.power_on  = 1'b0;
				st_kind.charge_on = 1'b1;
				st_kind.attached  = 1'b1;
			end
			KIND_KEYBOARD: begin
				st_kind.power_on  = 1'b1;
				st_kind.charge_on = 1'b0;
				st_kind.attached  = 1'b1;
			end
			default: begin
				st_kind.countdown   = retry_q;
				st_kind.timer_armed = 1'b1;
			end
		endcase
	end

	always_comb begin
		st_d          = st_q;
		cnt_dec       = (st_q.countdown != '0) ? st_q.countdown - 1'b1 : '0;
		case (word_s1.cmd)
			CMD_TICK: begin
				if (st_q.timer_armed) begin
					st_d.countdown = cnt_dec;
					if (cnt_dec == '0) begin
						st_d.timer_armed = 1'b0;
						st_d.awaiting    = 1'b1;
					end
				end
			end
			CMD_EDGE: begin
				if (st_q.watch) begin
					st_d.countdown   = debounce_q;
					st_d.timer_armed = 1'b1;
					st_d.awaiting    = 1'b0;
				end
			end
			CMD_SAMPLE: begin
				// a sample nobody asked for is dropped
				if (st_q.awaiting) begin
					st_d          = st_kind;
					st_d.awaiting = 1'b0;
					st_d.watch    = 1'b1;
				end
			end
			CMD_FORCE: begin
				if (word_s1.force_value == FORCE_DETACH ||
				    word_s1.force_value == FORCE_ATTACH) begin
					st_d          = st_kind;
					st_d.watch    = 1'b0;
				end else begin
					st_d.watch       = 1'b1;
					st_d.countdown   = '0;
					st_d.timer_armed = 1'b1;
					st_d.awaiting    = 1'b0;
				end
			end
			CMD_INIT: begin
				// zero countdown: sample request on the next tick
				st_d.watch       = 1'b1;
				st_d.countdown   = '0;
				st_d.timer_armed = 1'b1;
				st_d.awaiting    = 1'b0;
			end
			CMD_SHUTDOWN: begin
				st_d.watch    = 1'b0;
				st_d.power_on = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.countdown   <= '0;
			st_q.timer_armed <= 1'b0;
			st_q.awaiting    <= 1'b0;
			st_q.watch       <= 1'b0;
			st_q.kind        <= KIND_DETACHED;
			st_q.power_on    <= 1'b0;
			st_q.charge_on   <= 1'b0;
			st_q.attached    <= 1'b0;
		end else if (advance) begin
			st_q <= st_d;
		end
	end

	// stage 2: output register, holds while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word.sample_request    <= st_d.awaiting;
			out_word.power_enable      <= st_d.power_on;
			out_word.charge_enable     <= st_d.charge_on;
			out_word.base_attached     <= st_d.attached;
			out_word.device_kind       <= st_d.kind;
			out_word.external_power    <= HAS_DOCK && (st_d.kind == KIND_DOCK) &&
			                              word_s1.vbus_present;
			out_word.pin_watch_enabled <= st_d.watch;
		end
	end

endmodule

// ===== rtl/drid_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drid_classify: divider voltage classifier
// Priority: error flag, then window match: detached, dock (if built in), keyboard, else unknown.
// ----------------------------------------------------------------------------
module drid_classify
	import drid_pkg::*;
(
	input  logic [MV_W-1:0] mv,
	input  logic            err,
	input  windows_t        win,
	output logic [2:0]      kind
);

	logic hit_det, hit_dock, hit_kb;

	assign hit_det  = (win.det_low <= mv) && (mv <= win.det_high);
	assign hit_dock = HAS_DOCK && (win.dock_low <= mv) && (mv <= win.dock_high);
	assign hit_kb   = (win.kb_low <= mv) && (mv <= win.kb_high);

	always_comb begin
		if (err) begin
			kind = KIND_ERROR;
		end else if (hit_det) begin
			kind = KIND_DETACHED;
		end else if (hit_dock) begin
			kind = KIND_DOCK;
		end else if (hit_kb) begin
			kind = KIND_KEYBOARD;
		end else begin
			kind = KIND_UNKNOWN;
		end
	end

endmodule

// ===== rtl/drid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drid_checker: port-level checks for the resistor-ID detector
// Output word stability under stall and consistency of the reported status.
// ----------------------------------------------------------------------------
module drid_checker
	import drid_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	a_power_attached: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.power_enable |-> out_word.base_attached)
		else $error("supply on without an attached base");

	a_power_charge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_word.power_enable && out_word.charge_enable))
		else $error("supply and charging both enabled");

	a_ext_power: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.external_power |->
			out_word.charge_enable && (out_word.device_kind == KIND_DOCK))
		else $error("external power without a charging dock");

endmodule

bind debounced_resistor_id_detect drid_checker u_drid_checker (.*);
